[rtl/i2a_pkg.sv]
// Types and constants shared by the integer to ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  localparam logic [1:0] KIND_HEX_PAD = 2'd0;
  localparam logic [1:0] KIND_HEX_NLZ = 2'd1;
  localparam logic [1:0] KIND_UNS_DEC = 2'd2;
  localparam logic [1:0] KIND_SGN_DEC = 2'd3;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned NUM_HEX  = 8;
  localparam int unsigned NUM_DEC  = 10;
  localparam int unsigned DIGITS_W = 4 * NUM_DEC;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ALPHA_GAP   = 7'd7;
  localparam logic [3:0]        MAX_DEC     = 4'h9;
  localparam logic [3:0]        DABBLE_MIN  = 4'd5;
  localparam logic [3:0]        DABBLE_ADD  = 4'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/integer_to_ascii_converter.sv]
// Integer to ASCII converter: hex and decimal text, one character per word.
`timescale 1ns / 1ps
`default_nettype none

// Converts one 32-bit word to ASCII text, most significant character first,
// with last set on the final character. Hex kinds load 8 nibbles; decimal
// kinds run a bit-serial double dabble over the 32 magnitude bits, then emit
// a minus sign for a negative signed value. The nibbles or 10 BCD digits
// shift out one per cycle while the output is not stalled, leading zeros
// skipped one per cycle except in padded hex. A new word is taken once the
// last character has moved into the output register.
module integer_to_ascii_converter
  import i2a_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output out_word_t     out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [DIGITS_W-1:0]   digits_q, digits_d;
  logic [VALUE_W-1:0]    bin_q;
  logic [4:0]            cnt_q;
  logic [3:0]            rem_q;
  logic                  started_q;
  logic                  neg_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  skip;
  logic                  out_load;
  logic [3:0]            top;
  logic [CHAR_W-1:0]     top_char;
  logic [VALUE_W-1:0]    mag;
  logic                  bcd_ok;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign top      = digits_q[DIGITS_W-1 -: 4];
  assign top_char = ASCII_ZERO + CHAR_W'(top) + ((top > MAX_DEC) ? ALPHA_GAP : '0);
  assign mag      = (in_word_i.kind == KIND_SGN_DEC && in_word_i.value[VALUE_W-1])
                    ? (VALUE_W'(0) - in_word_i.value) : in_word_i.value;
  assign skip     = !started_q && top == 4'h0 && rem_q > 4'd1;
  assign out_load = out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT && !skip));

  // Add-3 correction on every BCD digit of five or more, then shift in the next binary bit.
  always_comb begin
    logic [DIGITS_W-1:0] adj;
    adj    = digits_q;
    bcd_ok = 1'b1;
    for (int i = 0; i < NUM_DEC; i++) begin
      if (digits_q[4*i +: 4] >= DABBLE_MIN) begin
        adj[4*i +: 4] = digits_q[4*i +: 4] + DABBLE_ADD;
      end
      if (digits_q[4*i +: 4] > MAX_DEC) begin
        bcd_ok = 1'b0;
      end
    end
    digits_d = {adj[DIGITS_W-2:0], bin_q[VALUE_W-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      digits_q    <= '0;
      bin_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      started_q   <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_word_i.kind == KIND_HEX_PAD || in_word_i.kind == KIND_HEX_NLZ) begin
              digits_q  <= {in_word_i.value, 8'h00};
              rem_q     <= 4'(NUM_HEX);
              started_q <= (in_word_i.kind == KIND_HEX_PAD);
              neg_q     <= 1'b0;
              state_q   <= ST_EMIT;
            end else begin
              digits_q  <= '0;
              bin_q     <= mag;
              cnt_q     <= '0;
              rem_q     <= 4'(NUM_DEC);
              started_q <= 1'b0;
              neg_q     <= (in_word_i.kind == KIND_SGN_DEC) && in_word_i.value[VALUE_W-1];
              state_q   <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          digits_q <= digits_d;
          bin_q    <= {bin_q[VALUE_W-2:0], 1'b0};
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == 5'(VALUE_W - 1)) begin
            state_q <= neg_q ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_q.character <= ASCII_MINUS;
            out_q.last      <= 1'b0;
            state_q         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip) begin
            digits_q <= {digits_q[DIGITS_W-5:0], 4'h0};
            rem_q    <= rem_q - 4'd1;
          end else if (out_free) begin
            out_q.character <= top_char;
            out_q.last      <= (rem_q == 4'd1);
            started_q       <= 1'b1;
            digits_q        <= {digits_q[DIGITS_W-5:0], 4'h0};
            rem_q           <= rem_q - 4'd1;
            if (rem_q == 4'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted word did not start conversion");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> rem_q != 4'd0 && rem_q <= 4'(NUM_DEC))
    else $error("digit count out of range");

  a_bcd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> bcd_ok)
    else $error("BCD digit above nine during double dabble");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && rem_q == 4'd1 && out_free) |=> out_valid_q && out_q.last)
    else $error("final character not marked last");

endmodule

`default_nettype wire
